### hw/rtl/button_debounce_hold_timer_core_assert.svh
// Assertion macros used by the button debounce hold timer top level.
`ifndef BUTTON_DEBOUNCE_HOLD_TIMER_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_TIMER_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define BDH_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error("bdh: same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define BDH_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error("bdh: next-cycle check failed");

`endif

### hw/rtl/bdh_pkg.sv
// Types and constants of the button debounce hold timer.
package bdh_pkg;

	localparam int BUTTONS = 5;
	localparam int MASK_W  = 5;
	localparam int TIME_W  = 32;
	localparam int DEB_W   = 16;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = DEB_W'(20);
	localparam logic [MASK_W-1:0] BTN_MASK       = MASK_W'((1 << BUTTONS) - 1);

	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [TIME_W-1:0] ms_t;
	typedef logic [DEB_W-1:0]  deb_t;

	typedef struct packed {
		mask_t raw_buttons;
		ms_t   now_ms;
	} poll_t;

	typedef struct packed {
		mask_t             raw_mask;
		mask_t             debounced_down;
		mask_t             press_edges;
		mask_t             release_edges;
		ms_t [MASK_W-1:0]  hold_time;
	} result_t;

endpackage

### hw/rtl/bdh_in_if.sv
// Poll channel: raw button mask and millisecond timestamp.
interface bdh_in_if;
	import bdh_pkg::*;

	logic  valid;
	logic  ready;
	mask_t raw_buttons;
	ms_t   now_ms;

	modport source (output valid, output raw_buttons, output now_ms, input ready);
	modport sink   (input valid, input raw_buttons, input now_ms, output ready);
endinterface

### hw/rtl/bdh_out_if.sv
// Result channel: raw and debounced masks, edges and hold times.
interface bdh_out_if;
	import bdh_pkg::*;

	logic  valid;
	logic  ready;
	mask_t raw_mask;
	mask_t debounced_down;
	mask_t press_edges;
	mask_t release_edges;
	ms_t   hold_time_0;
	ms_t   hold_time_1;
	ms_t   hold_time_2;
	ms_t   hold_time_3;
	ms_t   hold_time_4;

	modport source (
		output valid, output raw_mask, output debounced_down,
		output press_edges, output release_edges,
		output hold_time_0, output hold_time_1, output hold_time_2,
		output hold_time_3, output hold_time_4,
		input  ready
	);
	modport sink (
		input  valid, input raw_mask, input debounced_down,
		input  press_edges, input release_edges,
		input  hold_time_0, input hold_time_1, input hold_time_2,
		input  hold_time_3, input hold_time_4,
		output ready
	);
endinterface

### hw/rtl/bdh_cfg_if.sv
// Configuration write channel carrying the debounce time.
interface bdh_cfg_if;
	import bdh_pkg::*;

	logic valid;
	logic ready;
	deb_t debounce_time;

	modport source (output valid, output debounce_time, input ready);
	modport sink   (input valid, input debounce_time, output ready);
endinterface

### hw/rtl/bdh_step.sv
// Debounce state registers and the single-pass update of one poll.
module bdh_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  bdh_pkg::poll_t  poll_in,
	input  bdh_pkg::deb_t   debounce_time,
	output bdh_pkg::result_t result_out,
	output bdh_pkg::mask_t  stable_mask
);
	import bdh_pkg::*;

	mask_t last_raw_q;
	mask_t stable_q;
	ms_t   change_time_q;

	mask_t raw;
	logic  raw_chg;
	mask_t last_raw_d;
	ms_t   change_d;
	ms_t   elapsed;
	logic  settle;
	mask_t stable_d;
	mask_t pressed;
	mask_t released;
	ms_t [MASK_W-1:0] hold;

	always_comb begin
		raw        = poll_in.raw_buttons & BTN_MASK;
		raw_chg    = (raw != last_raw_q);
		last_raw_d = raw_chg ? raw : last_raw_q;
		change_d   = raw_chg ? poll_in.now_ms : change_time_q;
		elapsed    = poll_in.now_ms - change_d;
		settle     = (stable_q != last_raw_d) &&
			(elapsed >= {{(TIME_W-DEB_W){1'b0}}, debounce_time});
		stable_d   = settle ? last_raw_d : stable_q;
		pressed    = stable_d & ~stable_q & BTN_MASK;
		released   = stable_q & ~stable_d & BTN_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= '0;
			stable_q      <= '0;
			change_time_q <= '0;
		end else if (advance) begin
			last_raw_q    <= last_raw_d;
			stable_q      <= stable_d;
			change_time_q <= change_d;
		end
	end

	for (genvar i = 0; i < MASK_W; i++) begin : g_btn
		if (i < BUTTONS) begin : g_used
			ms_t press_time_q;
			ms_t press_time_d;

			always_comb begin
				press_time_d = press_time_q;
				if (pressed[i])
					press_time_d = poll_in.now_ms;
				if (released[i])
					press_time_d = '0;
			end

			assign hold[i] = stable_d[i] ? (poll_in.now_ms - press_time_d) : '0;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					press_time_q <= '0;
				end else if (advance) begin
					press_time_q <= press_time_d;
				end
			end
		end else begin : g_unused
			assign hold[i] = '0;
		end
	end

	assign result_out  = {last_raw_d, stable_d, pressed, released, hold};
	assign stable_mask = stable_q;

endmodule

### hw/rtl/button_debounce_hold_timer_core.sv
// Top level of the button debounce hold timer: channels, stages and config.
//
// Usage:
//   poll   - one beat per poll: raw_buttons (5-bit pressed mask) and now_ms
//            (free-running 32-bit millisecond time).
//   result - one beat per poll: raw and debounced masks, press and release
//            edges against the previous debounced mask, and the hold time of
//            each debounced button (zero for buttons that are up).
//   cfg    - write debounce_time (ms); always ready. Write only while idle.
// Path: an accepted poll beat is registered in the input stage, passes
//   through the update logic and is held in the output register for result.
// Throughput: one poll per cycle while result is not held off; the debounce
//   state is read and written once per poll in a single pass of logic.
// Reset: the debounce state and hold timers clear to zero, debounce_time
//   returns to 20 ms and both stages empty.
// Stall: while result is held off the output register keeps its beat; the
//   input stage still takes one more poll if it is empty, then poll.ready
//   drops until the result beat is taken.
`include "button_debounce_hold_timer_core_assert.svh"

module button_debounce_hold_timer_core (
	input  logic       clk,
	input  logic       arst_n,
	bdh_in_if.sink     poll,
	bdh_out_if.source  result,
	bdh_cfg_if.sink    cfg
);
	import bdh_pkg::*;

	// input stage
	logic    v_s1;
	poll_t   poll_s1;
	// output stage
	logic    v_s2;
	result_t result_s2;

	deb_t    debounce_q;
	logic    take_s2;
	logic    adv_s1;
	result_t step_result;
	mask_t   stable_mask;

	// The output register frees up when empty or when its beat is taken.
	assign take_s2    = !v_s2 || result.ready;
	assign adv_s1     = v_s1 && take_s2;
	assign poll.ready = !v_s1 || take_s2;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			debounce_q <= DEBOUNCE_RESET;
		end else begin
			if (poll.ready)
				v_s1 <= poll.valid;
			if (take_s2)
				v_s2 <= v_s1;
			if (cfg.valid)
				debounce_q <= cfg.debounce_time;
		end
	end

	// Payload registers: capture on acceptance, hold otherwise.
	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1.raw_buttons <= poll.raw_buttons;
			poll_s1.now_ms      <= poll.now_ms;
		end
		if (adv_s1)
			result_s2 <= step_result;
	end

	// Update the debounce state as the beat leaves the input stage.
	bdh_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (adv_s1),
		.poll_in       (poll_s1),
		.debounce_time (debounce_q),
		.result_out    (step_result),
		.stable_mask   (stable_mask)
	);

	assign result.valid          = v_s2;
	assign result.raw_mask       = result_s2.raw_mask;
	assign result.debounced_down = result_s2.debounced_down;
	assign result.press_edges    = result_s2.press_edges;
	assign result.release_edges  = result_s2.release_edges;
	assign result.hold_time_0    = result_s2.hold_time[0];
	assign result.hold_time_1    = result_s2.hold_time[1];
	assign result.hold_time_2    = result_s2.hold_time[2];
	assign result.hold_time_3    = result_s2.hold_time[3];
	assign result.hold_time_4    = result_s2.hold_time[4];

	// The beat on offer always carries the mask now held in the state.
	`BDH_ASSERT_NOW(a_stable_match, clk, arst_n, result.valid, result.debounced_down == stable_mask)
	// An accepted poll always lands in the input stage.
	`BDH_ASSERT_NEXT(a_poll_lands, clk, arst_n, poll.valid && poll.ready, v_s1)
	// A beat leaving the input stage is offered on the next cycle.
	`BDH_ASSERT_NEXT(a_result_follows, clk, arst_n, adv_s1, result.valid)

endmodule
